[rtl/fpa_pkg.sv]
`default_nettype none
package fpa_pkg;

  // Number format
  localparam int FRACTION_BITS = 8;
  localparam logic [31:0] FIX_ONE = 32'd1 << FRACTION_BITS;

  // Divider: one quotient bit per stage over the shifted dividend
  localparam int DIV_BITS = 32 + FRACTION_BITS;
  localparam int PIPE_LEN = DIV_BITS + 1;

  // Stage where multiply and conversion results join the main lane
  localparam int MERGE_STAGE = 4;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // Operation codes on the kind port
  localparam logic [3:0] KIND_ADD        = 4'd0;
  localparam logic [3:0] KIND_SUB        = 4'd1;
  localparam logic [3:0] KIND_MUL        = 4'd2;
  localparam logic [3:0] KIND_DIV        = 4'd3;
  localparam logic [3:0] KIND_INC        = 4'd4;
  localparam logic [3:0] KIND_DEC        = 4'd5;
  localparam logic [3:0] KIND_COMPARE    = 4'd6;
  localparam logic [3:0] KIND_MAX        = 4'd7;
  localparam logic [3:0] KIND_MIN        = 4'd8;
  localparam logic [3:0] KIND_TO_INT     = 4'd9;
  localparam logic [3:0] KIND_FROM_INT   = 4'd10;
  localparam logic [3:0] KIND_FROM_FLOAT = 4'd11;
  localparam logic [3:0] KIND_TO_FLOAT   = 4'd12;

  // Compare outcomes
  localparam logic [1:0] ORD_LESS    = 2'd0;
  localparam logic [1:0] ORD_EQUAL   = 2'd1;
  localparam logic [1:0] ORD_GREATER = 2'd2;

  typedef enum logic [3:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_INC,
    OP_DEC,
    OP_CMP,
    OP_MAX,
    OP_MIN,
    OP_TO_INT,
    OP_FROM_INT,
    OP_FROM_FLOAT,
    OP_TO_FLOAT,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] fb;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef struct packed {
    logic        valid;
    op_t         op;
    logic [31:0] val;
    logic [31:0] flt;
    logic [1:0]  ord;
    logic        derr;
    logic        qneg;
  } lane_t;

endpackage
`default_nettype wire

[rtl/fpa_front.sv]
`default_nettype none
module fpa_front import fpa_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [3:0]         in_kind,
  input  wire logic signed [31:0] in_operand_a,
  input  wire logic signed [31:0] in_operand_b,
  input  wire logic [31:0]        in_float_bits,
  input  wire queue_status_t      q_stat,
  output logic                    push,
  output item_t                   push_item
);

  logic  valid_r, valid_nxt;
  item_t item_r;
  op_t   op_w;
  logic  accept;

  // Classify the kind code
  always_comb begin
    case (in_kind)
      KIND_ADD:        op_w = OP_ADD;
      KIND_SUB:        op_w = OP_SUB;
      KIND_MUL:        op_w = OP_MUL;
      KIND_DIV:        op_w = OP_DIV;
      KIND_INC:        op_w = OP_INC;
      KIND_DEC:        op_w = OP_DEC;
      KIND_COMPARE:    op_w = OP_CMP;
      KIND_MAX:        op_w = OP_MAX;
      KIND_MIN:        op_w = OP_MIN;
      KIND_TO_INT:     op_w = OP_TO_INT;
      KIND_FROM_INT:   op_w = OP_FROM_INT;
      KIND_FROM_FLOAT: op_w = OP_FROM_FLOAT;
      KIND_TO_FLOAT:   op_w = OP_TO_FLOAT;
      default:         op_w = OP_NONE;
    endcase
  end

  // Hold the transaction until the queue takes it
  assign in_stall  = valid_r && q_stat.full;
  assign accept    = in_valid && !in_stall;
  assign push      = valid_r && !q_stat.full;
  assign push_item = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (push) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.op <= op_w;
      item_r.a  <= in_operand_a;
      item_r.b  <= in_operand_b;
      item_r.fb <= in_float_bits;
    end
  end

endmodule
`default_nettype wire

[rtl/fpa_queue.sv]
`default_nettype none
module fpa_queue import fpa_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire item_t push_item,
  input  wire logic  pop,
  output item_t      head,
  output queue_status_t stat
);

  item_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign head       = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);

  // Advance pointers with wrap
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
  end

  // Track fill level
  always_comb begin
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

[rtl/fpa_div.sv]
`default_nettype none
module fpa_div import fpa_pkg::*; (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [31:0] dvd_mag,
  input  wire logic [31:0] dvs_mag,
  output logic [31:0]      quo
);

  logic [DIV_BITS-1:0] num_r [PIPE_LEN];
  logic [31:0]         rem_r [PIPE_LEN];
  logic [31:0]         dvs_r [PIPE_LEN];
  logic [31:0]         quo_r [PIPE_LEN];

  logic [DIV_BITS-1:0] num_nxt [PIPE_LEN];
  logic [31:0]         rem_nxt [PIPE_LEN];
  logic [31:0]         dvs_nxt [PIPE_LEN];
  logic [31:0]         quo_nxt [PIPE_LEN];
  logic [32:0]         trial_w [PIPE_LEN];
  logic [32:0]         diff_w  [PIPE_LEN];
  logic                ge_w    [PIPE_LEN];

  // Load the shifted dividend, then one restoring step per stage
  always_comb begin
    num_nxt[0] = {dvd_mag, {FRACTION_BITS{1'b0}}};
    rem_nxt[0] = '0;
    dvs_nxt[0] = dvs_mag;
    quo_nxt[0] = '0;
    trial_w[0] = '0;
    diff_w[0]  = '0;
    ge_w[0]    = 1'b0;
    for (int k = 1; k < PIPE_LEN; k++) begin
      trial_w[k] = {rem_r[k-1], num_r[k-1][DIV_BITS-1]};
      diff_w[k]  = trial_w[k] - {1'b0, dvs_r[k-1]};
      ge_w[k]    = (trial_w[k] >= {1'b0, dvs_r[k-1]});
      rem_nxt[k] = ge_w[k] ? diff_w[k][31:0] : trial_w[k][31:0];
      quo_nxt[k] = {quo_r[k-1][30:0], ge_w[k]};
      num_nxt[k] = num_r[k-1] << 1;
      dvs_nxt[k] = dvs_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < PIPE_LEN; k++) begin
        num_r[k] <= num_nxt[k];
        rem_r[k] <= rem_nxt[k];
        dvs_r[k] <= dvs_nxt[k];
        quo_r[k] <= quo_nxt[k];
      end
    end
  end

  assign quo = quo_r[PIPE_LEN-1];

endmodule
`default_nettype wire

[rtl/fpa_back.sv]
`default_nettype none
module fpa_back import fpa_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire queue_status_t q_stat,
  input  wire item_t         head,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic signed [31:0] out_result_value,
  output logic [31:0]        out_result_float,
  output logic [1:0]         out_order,
  output logic               out_divide_error
);

  logic  en;
  lane_t lane_r   [PIPE_LEN];
  lane_t lane_nxt [PIPE_LEN];

  logic [31:0] a_mag_w, b_mag_w, quo_w;
  logic signed [63:0] prod_w;

  // Float decode at entry
  logic [7:0]        fe_w, eeff_w;
  logic [22:0]       fm23_w;
  logic [23:0]       fm24_w;
  logic signed [9:0] fs_w;

  // Side stage registers
  logic signed [63:0] s0_prod_r;
  logic               s0_fsign_r, s0_fnan_r, s0_finf_r, s0_fzero_r;
  logic signed [9:0]  s0_fs_r;
  logic [23:0]        s0_fm_r;
  logic               s0_xsign_r;
  logic [31:0]        s0_xmag_r;

  logic [31:0] s1_mul_r, s1_mul_nxt;
  logic [63:0] s1_fmag_r, s1_fmag_nxt;
  logic        s1_fsign_r, s1_fnan_r, s1_finf_r, s1_fzero_r;
  logic        s1_xsign_r;
  logic [31:0] s1_xmag_r;
  logic [3:0]  s1_bnz_r, s1_bnz_nxt;
  logic [2:0]  s1_bpos_r [4];
  logic [2:0]  s1_bpos_nxt [4];

  logic [31:0] s2_mul_r;
  logic [31:0] s2_f2x_r, s2_f2x_nxt;
  logic        s2_xsign_r;
  logic        s2_xzero_r, s2_xzero_nxt;
  logic [31:0] s2_norm_r, s2_norm_nxt;
  logic [4:0]  s2_p_r, s2_p_nxt;

  logic [31:0] s3_mul_r, s3_f2x_r;
  logic [31:0] s3_flt_r, s3_flt_nxt;

  logic        out_valid_r;
  logic [31:0] out_val_r, out_flt_r, fin_val_w;
  logic [1:0]  out_ord_r;
  logic        out_derr_r;

  // Advance everything when the output slot is free or taken
  assign en  = !out_valid_r || !out_stall;
  assign pop = !q_stat.empty && en;

  assign a_mag_w = head.a[31] ? (~head.a + 32'd1) : head.a;
  assign b_mag_w = head.b[31] ? (~head.b + 32'd1) : head.b;
  assign prod_w  = $signed(head.a) * $signed(head.b);

  fpa_div u_div (
    .clk     (clk),
    .en      (en),
    .dvd_mag (a_mag_w),
    .dvs_mag (b_mag_w),
    .quo     (quo_w)
  );

  // Entry: simple operations finish here
  always_comb begin
    lane_nxt[0].valid = pop;
    lane_nxt[0].op    = head.op;
    lane_nxt[0].val   = '0;
    lane_nxt[0].flt   = '0;
    lane_nxt[0].ord   = ORD_LESS;
    lane_nxt[0].derr  = (head.op == OP_DIV) && (head.b == '0);
    lane_nxt[0].qneg  = head.a[31] ^ head.b[31];
    case (head.op)
      OP_ADD:      lane_nxt[0].val = head.a + head.b;
      OP_SUB:      lane_nxt[0].val = head.a - head.b;
      OP_INC:      lane_nxt[0].val = head.a + FIX_ONE;
      OP_DEC:      lane_nxt[0].val = head.a - FIX_ONE;
      OP_MAX:      lane_nxt[0].val = ($signed(head.a) > $signed(head.b)) ? head.a : head.b;
      OP_MIN:      lane_nxt[0].val = ($signed(head.a) < $signed(head.b)) ? head.a : head.b;
      OP_TO_INT:   lane_nxt[0].val = 32'($signed(head.a) >>> FRACTION_BITS);
      OP_FROM_INT: lane_nxt[0].val = head.a << FRACTION_BITS;
      OP_CMP: begin
        if ($signed(head.a) < $signed(head.b)) begin
          lane_nxt[0].ord = ORD_LESS;
        end else if (head.a == head.b) begin
          lane_nxt[0].ord = ORD_EQUAL;
        end else begin
          lane_nxt[0].ord = ORD_GREATER;
        end
      end
      default:     lane_nxt[0].val = '0;
    endcase
  end

  // Shift the lane; multiply and conversions join at the merge stage
  always_comb begin
    for (int k = 1; k < PIPE_LEN; k++) begin
      lane_nxt[k] = lane_r[k-1];
      if (k == MERGE_STAGE) begin
        case (lane_r[k-1].op)
          OP_MUL:        lane_nxt[k].val = s3_mul_r;
          OP_FROM_FLOAT: lane_nxt[k].val = s3_f2x_r;
          OP_TO_FLOAT:   lane_nxt[k].flt = s3_flt_r;
          default:       lane_nxt[k].val = lane_r[k-1].val;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < PIPE_LEN; k++) begin
        lane_r[k].valid <= 1'b0;
      end
    end else if (en) begin
      for (int k = 0; k < PIPE_LEN; k++) begin
        lane_r[k] <= lane_nxt[k];
      end
    end
  end

  // Entry decode of the float operand
  always_comb begin
    fe_w   = head.fb[30:23];
    fm23_w = head.fb[22:0];
    fm24_w = (fe_w == 8'd0) ? {1'b0, fm23_w} : {1'b1, fm23_w};
    eeff_w = (fe_w == 8'd0) ? 8'd1 : fe_w;
    fs_w   = $signed({2'b00, eeff_w}) - 10'sd150 + 10'(FRACTION_BITS);
  end

  // Side stage 0
  always_ff @(posedge clk) begin
    if (en) begin
      s0_prod_r  <= prod_w;
      s0_fsign_r <= head.fb[31];
      s0_fnan_r  <= (fe_w == 8'hFF) && (fm23_w != '0);
      s0_finf_r  <= (fe_w == 8'hFF) && (fm23_w == '0);
      s0_fzero_r <= (fm24_w == '0);
      s0_fs_r    <= fs_w;
      s0_fm_r    <= fm24_w;
      s0_xsign_r <= head.a[31];
      s0_xmag_r  <= a_mag_w;
    end
  end

  // Side stage 1: product scaling, float magnitude, per-byte leading one
  always_comb begin
    logic [9:0]  rr;
    logic [24:0] rsum;
    logic [7:0]  byte_w;
    s1_mul_nxt = s0_prod_r[FRACTION_BITS+31:FRACTION_BITS];
    rr         = 10'(-s0_fs_r);
    rsum       = '0;
    if (!s0_fs_r[9]) begin
      if (s0_fs_r > 10'sd39) begin
        s1_fmag_nxt = 64'd1 << 40;
      end else begin
        s1_fmag_nxt = {40'd0, s0_fm_r} << s0_fs_r[5:0];
      end
    end else if (rr > 10'd24) begin
      s1_fmag_nxt = '0;
    end else begin
      rsum        = {1'b0, s0_fm_r} + (25'd1 << (rr[4:0] - 5'd1));
      s1_fmag_nxt = {39'd0, rsum >> rr[4:0]};
    end
    for (int j = 0; j < 4; j++) begin
      byte_w         = s0_xmag_r[8*j +: 8];
      s1_bnz_nxt[j]  = |byte_w;
      s1_bpos_nxt[j] = 3'd0;
      for (int i = 0; i < 8; i++) begin
        if (byte_w[i]) begin
          s1_bpos_nxt[j] = 3'(i);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_mul_r   <= s1_mul_nxt;
      s1_fmag_r  <= s1_fmag_nxt;
      s1_fsign_r <= s0_fsign_r;
      s1_fnan_r  <= s0_fnan_r;
      s1_finf_r  <= s0_finf_r;
      s1_fzero_r <= s0_fzero_r;
      s1_xsign_r <= s0_xsign_r;
      s1_xmag_r  <= s0_xmag_r;
      s1_bnz_r   <= s1_bnz_nxt;
      for (int j = 0; j < 4; j++) begin
        s1_bpos_r[j] <= s1_bpos_nxt[j];
      end
    end
  end

  // Side stage 2: saturate float result, normalize fixed magnitude
  always_comb begin
    logic [1:0] jh;
    if (s1_fnan_r || s1_fzero_r) begin
      s2_f2x_nxt = '0;
    end else if (s1_finf_r) begin
      s2_f2x_nxt = s1_fsign_r ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else if (s1_fsign_r) begin
      s2_f2x_nxt = (s1_fmag_r >= 64'h8000_0000) ? 32'h8000_0000 :
                   (~s1_fmag_r[31:0] + 32'd1);
    end else begin
      s2_f2x_nxt = (s1_fmag_r > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : s1_fmag_r[31:0];
    end
    jh = 2'd0;
    for (int j = 0; j < 4; j++) begin
      if (s1_bnz_r[j]) begin
        jh = 2'(j);
      end
    end
    s2_p_nxt     = {jh, s1_bpos_r[jh]};
    s2_xzero_nxt = (s1_bnz_r == '0);
    s2_norm_nxt  = s1_xmag_r << (5'd31 - s2_p_nxt);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_mul_r   <= s1_mul_r;
      s2_f2x_r   <= s2_f2x_nxt;
      s2_xsign_r <= s1_xsign_r;
      s2_xzero_r <= s2_xzero_nxt;
      s2_norm_r  <= s2_norm_nxt;
      s2_p_r     <= s2_p_nxt;
    end
  end

  // Side stage 3: round to nearest even and pack the single
  always_comb begin
    logic [23:0] m;
    logic [7:0]  low;
    logic        up;
    logic [24:0] mr;
    logic [22:0] mant;
    logic [7:0]  ex;
    m    = s2_norm_r[31:8];
    low  = s2_norm_r[7:0];
    up   = (low > 8'h80) || ((low == 8'h80) && m[0]);
    mr   = {1'b0, m} + {24'd0, up};
    mant = mr[24] ? 23'd0 : mr[22:0];
    ex   = {3'd0, s2_p_r} + 8'd127 - 8'(FRACTION_BITS) + {7'd0, mr[24]};
    s3_flt_nxt = s2_xzero_r ? 32'd0 : {s2_xsign_r, ex, mant};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_mul_r <= s2_mul_r;
      s3_f2x_r <= s2_f2x_r;
      s3_flt_r <= s3_flt_nxt;
    end
  end

  // Output register: attach the quotient
  always_comb begin
    fin_val_w = lane_r[PIPE_LEN-1].val;
    if (lane_r[PIPE_LEN-1].op == OP_DIV) begin
      if (lane_r[PIPE_LEN-1].derr) begin
        fin_val_w = '0;
      end else begin
        fin_val_w = lane_r[PIPE_LEN-1].qneg ? (~quo_w + 32'd1) : quo_w;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= lane_r[PIPE_LEN-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_val_r  <= fin_val_w;
      out_flt_r  <= lane_r[PIPE_LEN-1].flt;
      out_ord_r  <= lane_r[PIPE_LEN-1].ord;
      out_derr_r <= lane_r[PIPE_LEN-1].derr;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_val_r;
  assign out_result_float = out_flt_r;
  assign out_order        = out_ord_r;
  assign out_divide_error = out_derr_r;

endmodule
`default_nettype wire

[rtl/fixed_point_alu_core.sv]
`default_nettype none
// Channel   Direction  Handshake             Payload
// in_*      input      in_valid / in_stall   kind, operand_a, operand_b, float_bits
// out_*     output     out_valid / out_stall result_value, result_float, order, divide_error
//
// One transaction per cycle is accepted while in_stall is low, and one result per
// cycle is delivered while out_stall is low. The divider resolves one quotient bit
// per stage over a 32 + FRACTION_BITS bit dividend.
// Reset (rst_n low, synchronous) empties the front register, queue and pipeline.
// An output stall freezes the back pipeline; the front keeps filling the queue.
module fixed_point_alu_core import fpa_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [3:0]         in_kind,
  input  wire logic signed [31:0] in_operand_a,
  input  wire logic signed [31:0] in_operand_b,
  input  wire logic [31:0]        in_float_bits,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_result_value,
  output logic [31:0]             out_result_float,
  output logic [1:0]              out_order,
  output logic                    out_divide_error
);

  queue_status_t q_stat;
  logic          push, pop;
  item_t         push_item, head;

  fpa_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_operand_a  (in_operand_a),
    .in_operand_b  (in_operand_b),
    .in_float_bits (in_float_bits),
    .q_stat        (q_stat),
    .push          (push),
    .push_item     (push_item)
  );

  fpa_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  fpa_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_stat           (q_stat),
    .head             (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_value (out_result_value),
    .out_result_float (out_result_float),
    .out_order        (out_order),
    .out_divide_error (out_divide_error)
  );

  // A divide error carries no other result
  a_derr_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_divide_error |->
      out_result_value == '0 && out_result_float == '0 && out_order == ORD_LESS)
    else $error("divide error with nonzero result fields");

  // A float result never comes with a compare outcome or divide error
  a_flt_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_float != '0 |-> out_order == ORD_LESS && !out_divide_error)
    else $error("float result mixed with other outcome");

  // Compare outcome is always a legal code
  a_ord_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_order == ORD_LESS || out_order == ORD_EQUAL ||
                  out_order == ORD_GREATER)
    else $error("illegal compare outcome");

  // Nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule
`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 1ps
module tb;
  import fpa_pkg::*;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [3:0]         in_kind = KIND_ADD;
  logic signed [31:0] in_operand_a = '0;
  logic signed [31:0] in_operand_b = '0;
  logic [31:0]        in_float_bits = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_result_value;
  logic [31:0]        out_result_float;
  logic [1:0]         out_order;
  logic               out_divide_error;

  localparam int NUM_RANDOM = 1600;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = FRACTION_BITS + 60;

  typedef struct {
    logic [3:0]  kind;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] fb;
  } alu_op_t;

  typedef struct {
    logic [31:0] value;
    logic [31:0] flt;
    logic [1:0]  ord;
    logic        derr;
  } alu_res_t;

  // Directed row: typed expectation used when has_exp is set
  typedef struct {
    alu_op_t  op;
    bit       has_exp;
    alu_res_t res;
  } vector_t;

  alu_res_t pending_results[$];
  int       mismatch_count = 0;
  int       idle_cycles = 0;
  bit       stim_done = 1'b0;
  vector_t  vectors[$];

  fixed_point_alu_core DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Arithmetic shift right of a 64-bit value
  function automatic logic [63:0] shift_arith(logic [63:0] x, int n);
    logic signed [63:0] s;
    s = x;
    return s >>> n;
  endfunction

  // Float bits to fixed, round half away from zero, saturate
  function automatic logic [31:0] float_to_fix(logic [31:0] f);
    logic        sgn;
    int          ex;
    int          sh;
    logic [63:0] man;
    logic [63:0] mag;
    sgn = f[31];
    ex = int'(f[30:23]);
    man = {41'd0, f[22:0]};
    if (ex == 255) return (man != 0) ? 32'd0 : (sgn ? 32'h8000_0000 : 32'h7FFF_FFFF);
    if (ex == 0) ex = 1;
    else man[23] = 1'b1;
    if (man == 0) return 32'd0;
    sh = ex - 150 + FRACTION_BITS;
    if (sh >= 0) mag = (sh > 39) ? (64'd1 << 40) : (man << sh);
    else if (-sh > 40) mag = 0;
    else mag = (man + (64'd1 << (-sh - 1))) >> (-sh);
    if (sgn) return (mag >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-mag);
    return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
  endfunction

  // Fixed to float bits, round to nearest even
  function automatic logic [31:0] fix_to_float(logic signed [31:0] v);
    logic        sgn;
    logic [63:0] mag;
    logic [63:0] man;
    logic [63:0] low;
    logic [63:0] half;
    int          msb;
    int          r;
    sgn = v[31];
    mag = sgn ? -64'(v) : 64'(v);
    if (mag == 0) return 32'd0;
    msb = 0;
    for (int i = 0; i < 64; i++) if (mag[i]) msb = i;
    if (msb <= 23) man = mag << (23 - msb);
    else begin
      r = msb - 23;
      low = mag & ((64'd1 << r) - 1);
      half = 64'd1 << (r - 1);
      man = mag >> r;
      if (low > half || (low == half && man[0])) man++;
      if (man == (64'd1 << 24)) begin
        man >>= 1;
        msb++;
      end
    end
    return {sgn, 8'(msb - FRACTION_BITS + 127), man[22:0]};
  endfunction

  function automatic alu_res_t alu_predict(alu_op_t op);
    alu_res_t           r;
    logic signed [63:0] sa;
    logic signed [63:0] sb;
    logic signed [63:0] q;
    sa = $signed(op.a);
    sb = $signed(op.b);
    r = '{default: '0};
    case (op.kind)
      KIND_ADD:        r.value = op.a + op.b;
      KIND_SUB:        r.value = op.a - op.b;
      KIND_MUL:        r.value = 32'(shift_arith(sa * sb, FRACTION_BITS));
      KIND_DIV: begin
        if (sb == 0) r.derr = 1'b1;
        else begin
          q = (sa * (64'sd1 <<< FRACTION_BITS)) / sb;
          r.value = q[31:0];
        end
      end
      KIND_INC:        r.value = op.a + FIX_ONE;
      KIND_DEC:        r.value = op.a - FIX_ONE;
      KIND_COMPARE:    r.ord = (sa < sb) ? ORD_LESS : (sa == sb ? ORD_EQUAL : ORD_GREATER);
      KIND_MAX:        r.value = (sa > sb) ? op.a : op.b;
      KIND_MIN:        r.value = (sa < sb) ? op.a : op.b;
      KIND_TO_INT:     r.value = 32'(shift_arith(sa, FRACTION_BITS));
      KIND_FROM_INT:   r.value = op.a << FRACTION_BITS;
      KIND_FROM_FLOAT: r.value = float_to_fix(op.fb);
      KIND_TO_FLOAT:   r.flt = fix_to_float(op.a);
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s: got %h expected %h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic add_row(logic [3:0] k, logic [31:0] a, logic [31:0] b, logic [31:0] fb,
                         bit has_exp = 0, logic [31:0] ev = 0, logic [31:0] ef = 0,
                         logic [1:0] eo = 0, logic ed = 0);
    vector_t v;
    v.op = '{k, a, b, fb};
    v.has_exp = has_exp;
    v.res = '{ev, ef, eo, ed};
    vectors.push_back(v);
  endtask

  // Random operand word, biased toward extremes and small values
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000 + $urandom_range(0, 3);
      1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      2: return $urandom_range(0, 2048) - 1024;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_float();
    logic [31:0] f;
    f = $urandom;
    case ($urandom_range(0, 4))
      0: f[30:23] = 8'd255;
      1: f[30:23] = 8'd0;
      2: f[30:23] = 8'($urandom_range(100, 160));
      default: ;
    endcase
    return f;
  endfunction

  // Drive one transaction and hold until accepted
  task automatic send_op(alu_op_t op, bit has_exp, alu_res_t exp_res);
    in_valid <= 1'b1;
    in_kind <= op.kind;
    in_operand_a <= op.a;
    in_operand_b <= op.b;
    in_float_bits <= op.fb;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(has_exp ? exp_res : alu_predict(op));
  endtask

  task automatic maybe_gap(ref int burst);
    if (burst > 0) burst--;
    else begin
      burst = $urandom_range(0, 30);
      if ($urandom_range(0, 1)) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  endtask

  // Stimulus
  initial begin
    alu_op_t op;
    int      burst;
    burst = 0;
    add_row(KIND_ADD, 32'h7FFF_FFFF, 32'd1, 0, 1, 32'h8000_0000);
    add_row(KIND_SUB, 32'h8000_0000, 32'd1, 0, 1, 32'h7FFF_FFFF);
    add_row(KIND_MUL, 32'h8000_0000, 32'h8000_0000, 0);
    add_row(KIND_MUL, 32'hFFFF_FF00, 32'd256, 0, 1, 32'hFFFF_FF00);
    add_row(KIND_DIV, 32'd256, 32'd0, 0, 1, 0, 0, 0, 1'b1);
    add_row(KIND_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 0);
    add_row(KIND_DIV, 32'hFFFF_FD00, 32'd512, 0);
    add_row(KIND_INC, 32'h7FFF_FFFF, 0, 0);
    add_row(KIND_DEC, 32'h8000_0000, 0, 0);
    add_row(KIND_COMPARE, 32'h8000_0000, 32'h7FFF_FFFF, 0, 1, 0, 0, ORD_LESS);
    add_row(KIND_COMPARE, 32'd5, 32'd5, 0, 1, 0, 0, ORD_EQUAL);
    add_row(KIND_COMPARE, 32'h7FFF_FFFF, 32'h8000_0000, 0, 1, 0, 0, ORD_GREATER);
    add_row(KIND_MAX, 32'h8000_0000, 32'h7FFF_FFFF, 0, 1, 32'h7FFF_FFFF);
    add_row(KIND_MIN, 32'h8000_0000, 32'h7FFF_FFFF, 0, 1, 32'h8000_0000);
    add_row(KIND_TO_INT, 32'hFFFF_FFFF, 0, 0, 1, 32'hFFFF_FFFF);
    add_row(KIND_FROM_INT, 32'h7FFF_FFFF, 0, 0, 1, 32'hFFFF_FF00);
    add_row(KIND_FROM_FLOAT, 0, 0, 32'h7F80_0000, 1, 32'h7FFF_FFFF);
    add_row(KIND_FROM_FLOAT, 0, 0, 32'hFF80_0000, 1, 32'h8000_0000);
    add_row(KIND_FROM_FLOAT, 0, 0, 32'h7FC0_0001, 1, 0);
    add_row(KIND_FROM_FLOAT, 0, 0, 32'h8000_0000, 1, 0);
    add_row(KIND_FROM_FLOAT, 0, 0, 32'h3F80_0000, 1, 32'd256);
    add_row(KIND_FROM_FLOAT, 0, 0, 32'h3B00_0000);
    add_row(KIND_TO_FLOAT, 32'h8000_0000, 0, 0);
    add_row(KIND_TO_FLOAT, 32'd0, 0, 0, 1, 0, 0);
    add_row(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    foreach (vectors[i]) begin
      send_op(vectors[i].op, vectors[i].has_exp, vectors[i].res);
      maybe_gap(burst);
    end

    // Random operations with random bursts and gaps
    for (int n = 0; n < NUM_RANDOM; n++) begin
      op.kind = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(13, 15))
                                             : 4'($urandom_range(0, 12));
      op.a = rand_word();
      op.b = ($urandom_range(0, 9) == 0) ? 32'd0 : rand_word();
      op.fb = rand_float();
      send_op(op, 1'b0, '{default: '0});
      maybe_gap(burst);
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver stall pattern: quiet stretches and busy stretches
  initial begin
    int mode;
    forever begin
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(10, 60)) begin
        @(posedge clk);
        out_stall <= (mode == 0) ? 1'b0 : ($urandom_range(0, 3) < mode);
      end
    end
  end

  // Compare each transaction against the oldest expectation
  always @(posedge clk) begin
    alu_res_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", out_result_value, 0);
      end else begin
        w = pending_results.pop_front();
        if (out_result_value !== w.value)
          report_mismatch("result_value", out_result_value, w.value);
        if (out_result_float !== w.flt) report_mismatch("result_float", out_result_float, w.flt);
        if (out_order !== w.ord) report_mismatch("order", 32'(out_order), 32'(w.ord));
        if (out_divide_error !== w.derr)
          report_mismatch("divide_error", 32'(out_divide_error), 32'(w.derr));
      end
    end
  end

  // Watchdog: count cycles with no accepted transaction and no delivered result
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("fixed_point_alu_core regression: fail");
      $finish;
    end
  end

  // End of run
  initial begin
    wait (stim_done);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("fixed_point_alu_core regression: pass");
    end else begin
      $display("fixed_point_alu_core regression: fail");
    end
    $finish;
  end

endmodule
